@@ design/ncd_pkg.sv @@
// Shared types and constants for the nearest-car elevator dispatcher.
`default_nettype none
package ncd_pkg;

   localparam int CARS_DEF   = 4;
   localparam int FLOORS_DEF = 16;

   localparam int MODE_W  = 2;
   localparam int FLOOR_W = 4;
   localparam int CSEL_W  = 2;
   localparam int HEAD_W  = 2;

   localparam logic [MODE_W-1:0] MODE_CALL  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PLACE = 2'd2;

   localparam logic [HEAD_W-1:0] HEAD_UP   = 2'd0;
   localparam logic [HEAD_W-1:0] HEAD_DOWN = 2'd1;
   localparam logic [HEAD_W-1:0] HEAD_IDLE = 2'd2;

   typedef struct packed {
      logic load;
      logic exec;
   } ctl_type;

endpackage
`default_nettype wire

@@ design/ncd_ctrl.sv @@
// Controller: sequences accept, execute and result handoff for one item at a time.
`default_nettype none
module ncd_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output ncd_pkg::ctl_type  ctl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_RESP;
            rsp_valid_in = 1'b1;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign ctl.load  = req_valid && (state_ff == ST_IDLE);
   assign ctl.exec  = (state_ff == ST_EXEC);

endmodule
`default_nettype wire

@@ design/ncd_datapath.sv @@
// Datapath: car state, nearest-car search, lowest-stop encoder and result registers.
`default_nettype none
module ncd_datapath #(
   parameter int CARS   = ncd_pkg::CARS_DEF,
   parameter int FLOORS = ncd_pkg::FLOORS_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire ncd_pkg::ctl_type           ctl,
   input  wire [ncd_pkg::MODE_W-1:0]       req_mode,
   input  wire [ncd_pkg::FLOOR_W-1:0]      req_source_floor,
   input  wire [ncd_pkg::FLOOR_W-1:0]      req_target_floor,
   input  wire [ncd_pkg::CSEL_W-1:0]       req_car_select,
   output logic [ncd_pkg::CSEL_W-1:0]      rsp_car_index,
   output logic [ncd_pkg::FLOOR_W-1:0]     rsp_car_position,
   output logic [ncd_pkg::HEAD_W-1:0]      rsp_heading,
   output logic                            rsp_in_motion,
   output logic                            rsp_arrived,
   output logic                            rsp_stops_pending
);

   localparam int FW = $clog2(FLOORS);
   localparam int CW = (CARS > 1) ? $clog2(CARS) : 1;

   // latched item
   logic [ncd_pkg::MODE_W-1:0] mode_ff;
   logic [FW-1:0]              src_ff, dst_ff;
   logic [ncd_pkg::CSEL_W-1:0] sel_ff;
   logic [FW-1:0]              src_in, dst_in;

   // per-car state
   logic [FW-1:0]              floor_ff   [CARS];
   logic [FLOORS-1:0]          map_ff     [CARS];
   logic [ncd_pkg::HEAD_W-1:0] heading_ff [CARS];
   logic                       motion_ff  [CARS];

   // results
   logic [ncd_pkg::CSEL_W-1:0]  idx_ff, idx_in;
   logic [ncd_pkg::FLOOR_W-1:0] pos_ff, pos_in;
   logic [ncd_pkg::HEAD_W-1:0]  head_ff, head_in;
   logic                        mot_ff, mot_in;
   logic                        arr_ff, arr_in;
   logic                        pend_ff, pend_in;

   logic [CW-1:0]              best;
   logic [CW-1:0]              car;
   logic                       sel_ok;
   logic                       wr_en;
   logic [FW-1:0]              cur_floor;
   logic [FLOORS-1:0]          cur_map;
   logic [FW-1:0]              tgt;
   logic [FW-1:0]              floor_in;
   logic [FLOORS-1:0]          map_in;
   logic [ncd_pkg::HEAD_W-1:0] heading_in;
   logic                       motion_in;

   assign src_in = (32'(req_source_floor) >= 32'(FLOORS)) ? FW'(FLOORS - 1)
                                                          : FW'(req_source_floor);
   assign dst_in = (32'(req_target_floor) >= 32'(FLOORS)) ? FW'(FLOORS - 1)
                                                          : FW'(req_target_floor);

   always_comb begin : nearest
      logic [FW-1:0] d;
      logic [FW-1:0] bestd;
      best  = '0;
      bestd = '0;
      for (int i = 0; i < CARS; i++) begin
         d = (floor_ff[i] > src_ff) ? (floor_ff[i] - src_ff) : (src_ff - floor_ff[i]);
         if (i == 0 || d < bestd) begin
            best  = CW'(i);
            bestd = d;
         end
      end
   end

   assign sel_ok    = (32'(sel_ff) < 32'(CARS));
   assign car       = (mode_ff == ncd_pkg::MODE_CALL) ? best : CW'(sel_ff);
   assign cur_floor = floor_ff[car];
   assign cur_map   = map_ff[car];

   always_comb begin
      tgt = '0;
      for (int i = FLOORS - 1; i >= 0; i--) begin
         if (cur_map[i]) begin
            tgt = FW'(i);
         end
      end
   end

   always_comb begin
      floor_in   = cur_floor;
      map_in     = cur_map;
      heading_in = heading_ff[car];
      motion_in  = motion_ff[car];
      wr_en      = 1'b0;
      idx_in     = sel_ff;
      pos_in     = '0;
      head_in    = ncd_pkg::HEAD_IDLE;
      mot_in     = 1'b0;
      arr_in     = 1'b0;
      pend_in    = 1'b0;
      if (mode_ff == ncd_pkg::MODE_CALL) begin
         wr_en   = 1'b1;
         map_in  = cur_map | (FLOORS'(1) << src_ff) | (FLOORS'(1) << dst_ff);
         idx_in  = ncd_pkg::CSEL_W'(best);
         pos_in  = ncd_pkg::FLOOR_W'(cur_floor);
         head_in = heading_ff[car];
         mot_in  = motion_ff[car];
         pend_in = 1'b1;
      end else if (sel_ok) begin
         case (mode_ff)
            ncd_pkg::MODE_STEP: begin
               wr_en = 1'b1;
               if (cur_map == '0) begin
                  heading_in = ncd_pkg::HEAD_IDLE;
                  motion_in  = 1'b0;
               end else begin
                  heading_in = (tgt > cur_floor) ? ncd_pkg::HEAD_UP : ncd_pkg::HEAD_DOWN;
                  if (cur_floor < tgt) begin
                     floor_in = cur_floor + FW'(1);
                  end else if (cur_floor > tgt) begin
                     floor_in = cur_floor - FW'(1);
                  end
                  if (floor_in == tgt) begin
                     map_in    = cur_map & ~(FLOORS'(1) << tgt);
                     motion_in = 1'b0;
                     arr_in    = 1'b1;
                  end else begin
                     motion_in = 1'b1;
                  end
               end
               pos_in  = ncd_pkg::FLOOR_W'(floor_in);
               head_in = heading_in;
               mot_in  = motion_in;
               pend_in = (map_in != '0);
            end
            ncd_pkg::MODE_PLACE: begin
               wr_en      = 1'b1;
               floor_in   = src_ff;
               map_in     = '0;
               heading_in = ncd_pkg::HEAD_IDLE;
               motion_in  = 1'b0;
               pos_in     = ncd_pkg::FLOOR_W'(src_ff);
            end
            default: begin
               pos_in  = ncd_pkg::FLOOR_W'(cur_floor);
               head_in = heading_ff[car];
               mot_in  = motion_ff[car];
               pend_in = (cur_map != '0);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         mode_ff <= req_mode;
         src_ff  <= src_in;
         dst_ff  <= dst_in;
         sel_ff  <= req_car_select;
      end
      if (ctl.exec) begin
         idx_ff  <= idx_in;
         pos_ff  <= pos_in;
         head_ff <= head_in;
         mot_ff  <= mot_in;
         arr_ff  <= arr_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CARS; i++) begin
            floor_ff[i]   <= '0;
            map_ff[i]     <= '0;
            heading_ff[i] <= ncd_pkg::HEAD_IDLE;
            motion_ff[i]  <= 1'b0;
         end
      end else if (ctl.exec && wr_en) begin
         floor_ff[car]   <= floor_in;
         map_ff[car]     <= map_in;
         heading_ff[car] <= heading_in;
         motion_ff[car]  <= motion_in;
      end
   end

   assign rsp_car_index     = idx_ff;
   assign rsp_car_position  = pos_ff;
   assign rsp_heading       = head_ff;
   assign rsp_in_motion     = mot_ff;
   assign rsp_arrived       = arr_ff;
   assign rsp_stops_pending = pend_ff;

endmodule
`default_nettype wire

@@ design/nearest_car_elevator_dispatch_top.sv @@
// Sequence: an accepted item is latched, executed in the execute state, and its result registered.
// A new item is taken only after the result has been handed off, since each step
// depends on the car state it leaves.
// Reset: synchronous; all cars at floor 0, no stops, idle, not moving; no result pending.
`default_nettype none
module nearest_car_elevator_dispatch_top #(
   parameter int CARS   = ncd_pkg::CARS_DEF,
   parameter int FLOORS = ncd_pkg::FLOORS_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire [ncd_pkg::MODE_W-1:0]       req_mode,
   input  wire [ncd_pkg::FLOOR_W-1:0]      req_source_floor,
   input  wire [ncd_pkg::FLOOR_W-1:0]      req_target_floor,
   input  wire [ncd_pkg::CSEL_W-1:0]       req_car_select,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic [ncd_pkg::CSEL_W-1:0]      rsp_car_index,
   output logic [ncd_pkg::FLOOR_W-1:0]     rsp_car_position,
   output logic [ncd_pkg::HEAD_W-1:0]      rsp_heading,
   output logic                            rsp_in_motion,
   output logic                            rsp_arrived,
   output logic                            rsp_stops_pending
);

   ncd_pkg::ctl_type ctl;

   ncd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   ncd_datapath #(
      .CARS   (CARS),
      .FLOORS (FLOORS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .req_mode          (req_mode),
      .req_source_floor  (req_source_floor),
      .req_target_floor  (req_target_floor),
      .req_car_select    (req_car_select),
      .rsp_car_index     (rsp_car_index),
      .rsp_car_position  (rsp_car_position),
      .rsp_heading       (rsp_heading),
      .rsp_in_motion     (rsp_in_motion),
      .rsp_arrived       (rsp_arrived),
      .rsp_stops_pending (rsp_stops_pending)
   );

endmodule
`default_nettype wire
